@@ hdl/odr_pkg.sv @@
package odr_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HEAD,
      ST_DSQ_X,
      ST_DSQ_Y,
      ST_SQ1,
      ST_ROT1_PRE,
      ST_ROT1_GAIN,
      ST_ROT1_IT,
      ST_ROT1_END,
      ST_ROT2_PRE,
      ST_ROT2_GAIN,
      ST_ROT2_IT,
      ST_ROT2_END,
      ST_MDX,
      ST_MDY,
      ST_SQ2,
      ST_TRAVEL,
      ST_OUT
   } state_type;

   localparam logic [1:0] REG_HEADING_GAIN    = 2'd0;
   localparam logic [1:0] REG_MARKER_DISTANCE = 2'd1;
   localparam logic [1:0] REG_MARKER_ANGLE    = 2'd2;

   localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
   localparam int          ATAN_ENTRIES = 24;

   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/odometry_dead_reckoning.sv @@
// Dead-reckoning odometry with a virtual marker placed ahead of the robot.
//
// req_ channel: one raw odometry report per request. req_tready is high only
// while the block is idle; a request is taken when req_tvalid and req_tready
// are both high. rsp_ channel: one result per request, held in an output
// register until rsp_tready; the next request is taken and computed while it
// waits. csr_ channel: register writes (index 0 heading gain, 1 marker
// distance, 2 marker angle), accepted every cycle; write only while idle.
//
// The first report after reset skips the travel root. One shared 32-step
// square-root unit serves both the step length and the travel root, and one
// CORDIC rotator is used twice. A new request is taken only once the
// previous result has been loaded into the output register.
//
// Reset (synchronous, active high) clears the pose, marker and travel and
// restores register defaults; the first report after reset adds no travel.
// A stalled receiver holds the result; the next result then waits in the
// last step and no further request is taken until the register frees up.
module odometry_dead_reckoning #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [23:0] pose_x, [47:24] pose_y, [63:48] pose_heading, [65:64] speed_sign
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] est_x, [63:32] est_y, [79:64] est_heading, [111:80] marker_x,
   // [143:112] marker_y, [175:144] marker_travel
   output logic [175:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import odr_pkg::*;

   localparam int IW = $clog2(CORDIC_ITERS + 1);
   localparam int NI = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;

   state_type state_ff, state_in;

   logic [15:0] gain_ff, mdist_ff, mang_ff;
   logic [23:0] prev_x_ff, prev_y_ff;
   logic [15:0] prev_h_ff, heading_ff;
   logic [31:0] pos_x_ff, pos_y_ff, mark_x_ff, mark_y_ff, travel_ff;
   logic        first_ff;

   logic [23:0] in_x_ff, in_y_ff;
   logic [15:0] in_h_ff;
   logic [1:0]  in_s_ff;

   // shared datapath registers
   logic signed [32:0] dx_ff;       // fold sign, +1 or -1
   logic [63:0]        acc_ff;      // sum of squares
   logic [31:0]        len_ff;      // sqrt result, or marker distance for the second rotation
   logic signed [49:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic [IW-1:0]      it_ff;
   logic signed [33:0] rx_ff, ry_ff;  // second rotation result
   logic [175:0]       out_ff;
   logic               out_v_ff;

   // sqrt unit
   logic        sq_start, sq_done;
   logic [63:0] sq_rad;
   logic [31:0] sq_root;

   odr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .done(sq_done), .root(sq_root)
   );

   // ---- one multiplier, shared
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [16:0] dth;
   logic [15:0]        dth_raw;
   logic signed [23:0] pdx, pdy;
   logic signed [31:0] mdx, mdy;
   logic [31:0]        nmx, nmy;
   logic [31:0]        ang_a;
   logic [15:0]        rot_ang;
   logic signed [49:0] sh_x, sh_y;
   logic [4:0]         it5;
   logic signed [32:0] atn;
   logic signed [33:0] rnd_x, rnd_y;
   logic [32:0]        tsum;
   logic [31:0]        gprod;
   logic [63:0]        gfull;

   assign dth_raw = in_h_ff - prev_h_ff;
   assign dth = (dth_raw > 16'd32768) ? $signed({1'b1, dth_raw}) : $signed({1'b0, dth_raw});
   assign pdx = $signed(in_x_ff - prev_x_ff);
   assign pdy = $signed(in_y_ff - prev_y_ff);
   assign nmx = pos_x_ff + rx_ff[31:0];
   assign nmy = pos_y_ff + ry_ff[31:0];
   assign mdx = $signed(nmx - mark_x_ff);
   assign mdy = $signed(nmy - mark_y_ff);
   assign rot_ang = (state_ff == ST_ROT1_PRE) ? heading_ff : heading_ff + mang_ff;
   assign ang_a = {rot_ang, 16'h0000};
   assign it5 = 5'(it_ff);
   assign sh_x = cx_ff >>> it_ff;
   assign sh_y = cy_ff >>> it_ff;
   assign atn = $signed({1'b0, atan_lookup(it5)});
   assign rnd_x = 34'((cx_ff + 50'sd32768) >>> 16);
   assign rnd_y = 34'((cy_ff + 50'sd32768) >>> 16);
   assign gfull = {32'h0, len_ff} * {32'h0, CORDIC_GAIN};
   assign gprod = gfull[63:32];
   assign tsum = {1'b0, travel_ff} + {1'b0, sq_root};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_HEAD: begin
            mul_a = 34'(dth);
            mul_b = $signed({18'h0, gain_ff});
         end
         ST_DSQ_X: begin mul_a = 34'(pdx); mul_b = 34'(pdx); end
         ST_DSQ_Y: begin mul_a = 34'(pdy); mul_b = 34'(pdy); end
         ST_MDX:   begin mul_a = 34'(mdx); mul_b = 34'(mdx); end
         ST_MDY:   begin mul_a = 34'(mdy); mul_b = 34'(mdy); end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid && req_tready) state_in = ST_HEAD;
         ST_HEAD:      state_in = ST_DSQ_X;
         ST_DSQ_X:     state_in = ST_DSQ_Y;
         ST_DSQ_Y:     state_in = ST_SQ1;
         ST_SQ1:       if (sq_done) state_in = ST_ROT1_PRE;
         ST_ROT1_PRE:  state_in = ST_ROT1_GAIN;
         ST_ROT1_GAIN: state_in = ST_ROT1_IT;
         ST_ROT1_IT:   if (it_ff == IW'(NI - 1)) state_in = ST_ROT1_END;
         ST_ROT1_END:  state_in = ST_ROT2_PRE;
         ST_ROT2_PRE:  state_in = ST_ROT2_GAIN;
         ST_ROT2_GAIN: state_in = ST_ROT2_IT;
         ST_ROT2_IT:   if (it_ff == IW'(NI - 1)) state_in = ST_ROT2_END;
         ST_ROT2_END:  state_in = ST_MDX;
         ST_MDX:       state_in = ST_MDY;
         ST_MDY:       state_in = first_ff ? ST_OUT : ST_SQ2;
         ST_SQ2:       if (sq_done) state_in = ST_TRAVEL;
         ST_TRAVEL:    state_in = ST_OUT;
         ST_OUT:       if (!out_v_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      sq_start = (state_ff == ST_DSQ_Y) || (state_ff == ST_MDY && !first_ff);
      sq_rad = (state_ff == ST_DSQ_Y) ? ((acc_ff + 64'(mul_p)) << 16)
                                      : (acc_ff + 64'(mul_p));
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         gain_ff    <= 16'd16384;
         mdist_ff   <= 16'd2500;
         mang_ff    <= 16'd0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_h_ff  <= '0;
         heading_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         mark_x_ff  <= '0;
         mark_y_ff  <= '0;
         travel_ff  <= '0;
         first_ff   <= 1'b1;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               REG_HEADING_GAIN:    gain_ff  <= csr_data;
               REG_MARKER_DISTANCE: mdist_ff <= csr_data;
               REG_MARKER_ANGLE:    mang_ff  <= csr_data;
               default: ;
            endcase
         end
         if (out_v_ff && rsp_tready && state_ff != ST_OUT) out_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               in_x_ff <= req_tdata[23:0];
               in_y_ff <= req_tdata[47:24];
               in_h_ff <= req_tdata[63:48];
               in_s_ff <= req_tdata[65:64];
            end
            ST_HEAD: begin
               heading_ff <= heading_ff + 16'(68'(mul_p + 68'sd8192) >>> 14);
               prev_h_ff  <= in_h_ff;
            end
            ST_DSQ_X: acc_ff <= 64'(mul_p);
            ST_DSQ_Y: begin
               prev_x_ff <= in_x_ff;
               prev_y_ff <= in_y_ff;
            end
            ST_SQ1: if (sq_done) len_ff <= sq_root;
            ST_ROT1_PRE, ST_ROT2_PRE: begin
               if (state_ff == ST_ROT2_PRE) len_ff <= {8'h0, mdist_ff, 8'h0};
               // fold the angle into the right half plane
               if ((ang_a + 32'h4000_0000) >= 32'h8000_0000) begin
                  cz_ff <= 33'($signed(ang_a + 32'h8000_0000));
                  dx_ff <= -33'sd1;
               end else begin
                  cz_ff <= 33'($signed(ang_a));
                  dx_ff <= 33'sd1;
               end
            end
            ST_ROT1_GAIN, ST_ROT2_GAIN: begin
               cx_ff <= (dx_ff < 0) ? -$signed({2'b0, gprod, 16'h0})
                                    : $signed({2'b0, gprod, 16'h0});
               cy_ff <= '0;
               it_ff <= '0;
            end
            ST_ROT1_IT, ST_ROT2_IT: begin
               if (!cz_ff[32]) begin
                  cx_ff <= cx_ff - sh_y;
                  cy_ff <= cy_ff + sh_x;
                  cz_ff <= cz_ff - atn;
               end else begin
                  cx_ff <= cx_ff + sh_y;
                  cy_ff <= cy_ff - sh_x;
                  cz_ff <= cz_ff + atn;
               end
               it_ff <= it_ff + IW'(1);
            end
            ST_ROT1_END: begin
               if (in_s_ff != 2'b00 && len_ff != 32'd0) begin
                  if (in_s_ff[1]) begin
                     pos_x_ff <= pos_x_ff - rnd_x[31:0];
                     pos_y_ff <= pos_y_ff - rnd_y[31:0];
                  end else begin
                     pos_x_ff <= pos_x_ff + rnd_x[31:0];
                     pos_y_ff <= pos_y_ff + rnd_y[31:0];
                  end
               end
            end
            ST_ROT2_END: begin
               rx_ff <= rnd_x;
               ry_ff <= rnd_y;
            end
            ST_MDX: acc_ff <= 64'(mul_p);
            ST_MDY: begin
               acc_ff <= acc_ff + 64'(mul_p);
               if (first_ff) first_ff <= 1'b0;
            end
            ST_TRAVEL: travel_ff <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            ST_OUT: if (!out_v_ff || rsp_tready) begin
               mark_x_ff <= nmx;
               mark_y_ff <= nmy;
               out_ff <= {travel_ff, nmy, nmx, heading_ff, pos_y_ff, pos_x_ff};
               out_v_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_HEAD)
      else $error("request not started");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("held result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT1_IT) |-> it_ff < IW'(NI))
      else $error("cordic count overrun");

endmodule

@@ hdl/odr_sqrt.sv @@
module odr_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import odr_pkg::*;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // one result bit per cycle, the trial bit moves down two places each step
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule
